// ===== sv/stbs_pkg.sv =====
// Shared constants and types for the sorted table binary search block.
// Used by the search engine and the top level; depends on nothing.
package stbs_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = 10;
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int PROBE_W = 4;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [PROBE_W-1:0] PROBE_MAX = {PROBE_W{1'b1}};

    typedef struct packed {
        logic               found;
        logic [ADDR_W-1:0]  match_index;
        logic [PROBE_W-1:0] probe_count;
    } stbs_result_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] key;
    } stbs_request_t;

endpackage

// ===== sv/stbs_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Standalone; no package dependency.
module stbs_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/stbs_engine.sv =====
// Binary search sequencer: holds the table length register and the search bounds,
// issues one table read per probe and compares it with the key. Depends on stbs_pkg.
module stbs_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [stbs_pkg::LEN_W-1:0]    cfg_wr_data,
    input  stbs_pkg::stbs_request_t       req,
    output logic                          ready,
    output logic                          rd_en,
    output logic [stbs_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [stbs_pkg::DATA_W-1:0]   rd_data,
    output logic                          done_valid,
    input  logic                          out_free,
    output stbs_pkg::stbs_result_t        result
);
    import stbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [LEN_W-1:0]   hi_reg, hi_next;
    logic [ADDR_W-1:0]  mid_reg, mid_next;
    logic [DATA_W-1:0]  key_reg, key_next;
    logic [PROBE_W-1:0] probes_reg, probes_next;
    logic               found_reg, found_next;
    logic [ADDR_W-1:0]  match_reg, match_next;
    logic [LEN_W-1:0]   len_clamped;
    logic [LEN_W:0]     mid_sum;
    logic [LEN_W-1:0]   mid_full;
    logic [LEN_W-1:0]   mid_plus1;
    logic               hit;
    logic               below;

    assign len_clamped = (len_reg > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : len_reg;
    assign mid_sum     = {1'b0, left_reg} + {1'b0, hi_reg} - (LEN_W + 1)'(1);
    assign mid_full    = mid_sum[LEN_W:1];
    assign mid_plus1   = LEN_W'(mid_reg) + LEN_W'(1);
    assign hit         = (rd_data == key_reg);
    assign below       = $signed(rd_data) < $signed(key_reg);

    always_comb begin
        state_next  = state_reg;
        left_next   = left_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        key_next    = key_reg;
        probes_next = probes_reg;
        found_next  = found_reg;
        match_next  = match_reg;
        rd_en       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    key_next    = req.key;
                    left_next   = '0;
                    hi_next     = len_clamped;
                    probes_next = '0;
                    found_next  = 1'b0;
                    match_next  = '0;
                    state_next  = (len_clamped == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                mid_next   = mid_full[ADDR_W-1:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (probes_reg != PROBE_MAX) begin
                    probes_next = probes_reg + PROBE_W'(1);
                end
                if (hit) begin
                    found_next = 1'b1;
                    match_next = mid_reg;
                    state_next = ST_DONE;
                end else begin
                    if (below) begin
                        left_next = mid_plus1;
                    end else begin
                        hi_next = LEN_W'(mid_reg);
                    end
                    state_next = (left_next < hi_next) ? ST_READ : ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end
        end
        left_reg   <= left_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        probes_reg <= probes_next;
        found_reg  <= found_next;
        match_reg  <= match_next;
    end

    assign ready              = (state_reg == ST_IDLE);
    assign rd_addr            = mid_full[ADDR_W-1:0];
    assign done_valid         = (state_reg == ST_DONE);
    assign result.found       = found_reg;
    assign result.match_index = match_reg;
    assign result.probe_count = probes_reg;

`ifndef SYNTHESIS
    a_bounds_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (left_reg < hi_reg))
        else $error("Search bounds crossed while a probe was pending.");

    a_hi_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ || state_reg == ST_CMP) |-> (hi_reg <= LEN_W'(DEPTH)))
        else $error("Upper search bound lies beyond the table.");

    a_hit_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP && hit) |=> (state_reg == ST_DONE && found_reg))
        else $error("A matching probe did not end the search.");

    a_found_probed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && found_reg) |-> (probes_reg != '0))
        else $error("A match was reported without any probe.");
`endif

endmodule

// ===== sv/sorted_table_binary_search.sv =====
// Top level of the sorted table binary search block: stream handshakes, table memory,
// search engine and the result register. Depends on stbs_pkg, stbs_ram and stbs_engine.
//
//  Channel  Direction  Payload
//  s_       in         tuser: func; tdata: entry_index [9:0], value [41:10]
//  m_       out        tuser: found; tdata: match_index [9:0], probe_count [13:10]
//  cfg_     in         table_length [10:0], written when cfg_wr_en is high
//
// A write request leaves the block ready.
// A search request passes through a read state and a compare state for each probe,
// because the single table read port returns registered data.
// The result register lets the next request enter while a result waits on m_tready.
// Reset clears the control state and the table length; the table itself is not cleared.
module sorted_table_binary_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index [9:0], value [41:10], zero [47:42]
    input  logic [0:0]  s_tuser,   // func [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // match_index [9:0], probe_count [13:10], zero [15:14]
    output logic [0:0]  m_tuser,   // found [0]
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data
);
    import stbs_pkg::*;

    logic                s_accept;
    logic [ADDR_W-1:0]   s_entry_index;
    logic [DATA_W-1:0]   s_value;
    logic                tbl_wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [DATA_W-1:0]   rd_data;
    logic                eng_ready;
    logic                done_valid;
    logic                out_free;
    stbs_request_t       req;
    stbs_result_t        result;
    logic                m_valid_reg;
    stbs_result_t        m_result_reg;

    assign s_entry_index = s_tdata[ADDR_W-1:0];
    assign s_value       = s_tdata[ADDR_W+DATA_W-1:ADDR_W];
    assign s_tready      = eng_ready;
    assign s_accept      = s_tvalid && s_tready;
    assign tbl_wr_en     = s_accept && (s_tuser[0] == FUNC_WRITE);
    assign req.start     = s_accept && (s_tuser[0] == FUNC_SEARCH);
    assign req.key       = s_value;
    assign out_free      = !m_valid_reg || m_tready;

    stbs_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (s_entry_index),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .ready       (eng_ready),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .done_valid  (done_valid),
        .out_free    (out_free),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (done_valid && out_free) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_result_reg.found;
    assign m_tdata  = {2'b00, m_result_reg.probe_count, m_result_reg.match_index};

endmodule
